@@ sv/bcr_pkg.sv @@
package bcr_pkg;

    localparam int MAX_POINTS_DEF  = 8;
    localparam int MAX_ITER_DEF    = 128;
    localparam int T_FRAC_BITS_DEF = 24;
    localparam int RESULT_CAP      = 64;

    localparam logic [3:0]  POINT_COUNT_RST = 4'd4;
    localparam logic [30:0] GOAL_RST        = 31'd65536;
    localparam logic [30:0] TOL_RST         = 31'd6554;
    localparam logic [6:0]  LIMIT_RST       = 7'd64;

    typedef enum logic [1:0] {
        CFG_POINT_COUNT = 2'd0,
        CFG_GOAL        = 2'd1,
        CFG_TOLERANCE   = 2'd2,
        CFG_LIMIT       = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_RASTER = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_HI, S_SQ_LO, S_SQ_END, S_EGO, S_EWAIT,
        S_D0, S_D1, S_D2, S_D3, S_OUT, S_BST, S_BIT
    } t_state;

    typedef enum logic [2:0] {
        E_IDLE, E_LD0, E_LDA, E_MUL, E_UPD, E_RD
    } t_ev_state;

endpackage

@@ sv/bezier_equal_chord_raster.sv @@
// Channel  | Valid         | Stall/ready    | Payload
// input    | i_in_valid    | o_in_stall     | i_kind, i_point_index, i_x_coord, i_y_coord
// output   | o_out_valid   | i_out_stall    | o_point_x, o_point_y, o_point_valid, o_last_point
// config   | i_cfg_valid   | o_cfg_ready    | i_cfg_index, i_cfg_data
//
// A rasterize transaction first squares both chord thresholds, then evaluates x and y at
// t = 0 and t = 1; each de Casteljau evaluation is on one axis through the shared
// multiplier (n control points). Each trial t evaluates both axes, up to MAX_ITER trials
// per point. Every end check, the first included, measures the chord to the curve end;
// a point that is not the last restarts the search once it leaves the output register.
// Reset is synchronous and active low; the stored control points are not cleared.
// The input is stalled for the whole rasterize transaction, including while a result
// waits on a stalled output.
module bezier_equal_chord_raster import bcr_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int MAX_ITER    = MAX_ITER_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [2:0]  i_point_index,
    input  logic [31:0] i_x_coord,
    input  logic [31:0] i_y_coord,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic        o_point_valid,
    output logic        o_last_point,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int TW = T_FRAC_BITS + 1;
    localparam int BW = (TW > 32) ? TW : 32;
    localparam int PW = 32 + BW;
    localparam int IW = $clog2(MAX_ITER + 1);
    localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    t_state r_state, n_state;

    logic [3:0]  r_point_count;
    logic [30:0] r_goal, r_tol;
    logic [6:0]  r_limit_cfg;

    logic [31:0] r_hi, r_lo;
    logic [63:0] r_hi_sq, r_lo_sq, r_sx;
    logic [64:0] r_sum;
    logic [6:0]  r_limit, r_cnt;
    logic [NW-1:0] r_n, w_n;
    logic [31:0] r_last_x, r_last_y, r_end_x, r_end_y, r_tx, r_ty, r_my;
    logic [TW-1:0] r_last_t, r_t_low, r_t_high, r_t, w_tsum_t;
    logic [TW:0] w_tsum;
    logic [IW-1:0] r_iter;
    logic [1:0]  r_ev;
    logic        r_init, r_dchk, r_pend;

    logic        r_out_v, r_ovalid, r_olast;
    logic [31:0] r_ox, r_oy;

    logic        w_in_acc, w_out_acc, w_wr, w_ev_start, w_ev_done, w_stop;
    logic        w_lo_hit, w_hi_hit, w_iter_last;
    logic [TW-1:0] w_ev_t;
    logic [31:0] w_ev_res, w_ev_mul_a, w_mul_a, w_bx, w_by, w_hi_sum;
    logic [BW-1:0] w_ev_mul_b, w_mul_b;
    logic [PW-1:0] w_p;
    logic [32:0] w_dx, w_dy, w_mx, w_my;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_v && !i_out_stall;
    assign w_wr      = w_in_acc && (i_kind == KIND_LOAD) && (32'(i_point_index) < MAX_POINTS);

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_v;
    assign o_point_x     = r_ox;
    assign o_point_y     = r_oy;
    assign o_point_valid = r_ovalid;
    assign o_last_point  = r_olast;

    always_comb begin
        if (r_point_count < 4'd2) begin
            w_n = NW'(2);
        end else if (32'(r_point_count) > MAX_POINTS) begin
            w_n = NW'(MAX_POINTS);
        end else begin
            w_n = NW'(r_point_count);
        end
    end

    assign w_hi_sum = {1'b0, r_goal} + {1'b0, r_tol};
    assign w_tsum   = {1'b0, r_t_low} + {1'b0, r_t_high};
    assign w_tsum_t = w_tsum[TW:1];

    assign w_bx = r_dchk ? r_end_x : r_tx;
    assign w_by = r_dchk ? r_end_y : r_ty;
    assign w_dx = {r_last_x[31], r_last_x} - {w_bx[31], w_bx};
    assign w_dy = {r_last_y[31], r_last_y} - {w_by[31], w_by};
    assign w_mx = w_dx[32] ? -w_dx : w_dx;
    assign w_my = w_dy[32] ? -w_dy : w_dy;

    assign w_stop      = (r_sum < {1'b0, r_hi_sq}) || (r_cnt >= r_limit);
    assign w_lo_hit    = r_sum < {1'b0, r_lo_sq};
    assign w_hi_hit    = r_sum > {1'b0, r_hi_sq};
    assign w_iter_last = (r_iter == IW'(1));

    bcr_eval #(
        .MAX_POINTS  (MAX_POINTS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_wr_addr (AW'(i_point_index)),
        .i_wr_x    (i_x_coord),
        .i_wr_y    (i_y_coord),
        .i_start   (w_ev_start),
        .i_axis    (r_ev[0]),
        .i_t       (w_ev_t),
        .i_n       (r_n),
        .o_mul_a   (w_ev_mul_a),
        .o_mul_b   (w_ev_mul_b),
        .i_mul_p   (w_p),
        .o_done    (w_ev_done),
        .o_result  (w_ev_res)
    );

    bcr_mul #(
        .BW (BW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc && i_kind == KIND_RASTER) n_state = S_SQ_HI;
            S_SQ_HI:  n_state = S_SQ_LO;
            S_SQ_LO:  n_state = S_SQ_END;
            S_SQ_END: n_state = S_EGO;
            S_EGO:    n_state = S_EWAIT;
            S_EWAIT: begin
                if (w_ev_done) begin
                    if (r_init) begin
                        n_state = (r_ev == 2'd3) ? S_D0 : S_EGO;
                    end else begin
                        n_state = r_ev[0] ? S_D0 : S_EGO;
                    end
                end
            end
            S_D0:     n_state = S_D1;
            S_D1:     n_state = S_D2;
            S_D2:     n_state = S_D3;
            S_D3: begin
                if (r_dchk) begin
                    n_state = (r_pend || w_stop) ? S_OUT : S_BST;
                end else if ((w_lo_hit || w_hi_hit) && !w_iter_last) begin
                    n_state = S_BIT;
                end else begin
                    n_state = S_D0;
                end
            end
            S_OUT:    if (w_out_acc) n_state = r_olast ? S_IDLE : S_BST;
            S_BST:    n_state = S_BIT;
            S_BIT:    n_state = S_EGO;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_ev_start = (r_state == S_EGO);
        if (r_init) begin
            w_ev_t = r_ev[1] ? T_ONE : '0;
        end else begin
            w_ev_t = r_t;
        end
        unique case (r_state)
            S_SQ_HI: begin
                w_mul_a = r_hi;
                w_mul_b = BW'(r_hi);
            end
            S_SQ_LO: begin
                w_mul_a = r_lo;
                w_mul_b = BW'(r_lo);
            end
            S_D0: begin
                w_mul_a = w_mx[31:0];
                w_mul_b = BW'(w_mx[31:0]);
            end
            S_D1: begin
                w_mul_a = r_my;
                w_mul_b = BW'(r_my);
            end
            default: begin
                w_mul_a = w_ev_mul_a;
                w_mul_b = w_ev_mul_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RST;
            r_goal        <= GOAL_RST;
            r_tol         <= TOL_RST;
            r_limit_cfg   <= LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POINT_COUNT: r_point_count <= i_cfg_data[3:0];
                CFG_GOAL:        r_goal        <= i_cfg_data[30:0];
                CFG_TOLERANCE:   r_tol         <= i_cfg_data[30:0];
                CFG_LIMIT:       r_limit_cfg   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_D3 && r_dchk && (r_pend || w_stop)) begin
                r_out_v <= 1'b1;
                r_pend  <= 1'b0;
            end else if (w_out_acc) begin
                r_out_v <= 1'b0;
            end
            if (r_state == S_D3 && !r_dchk && !((w_lo_hit || w_hi_hit) && !w_iter_last)) begin
                r_pend <= 1'b1;
            end
        end
        case (r_state)
            S_IDLE: begin
                r_hi    <= w_hi_sum;
                r_lo    <= (r_goal > r_tol) ? {1'b0, r_goal - r_tol} : '0;
                r_n     <= w_n;
                r_limit <= (r_limit_cfg > 7'(RESULT_CAP)) ? 7'(RESULT_CAP) : r_limit_cfg;
                r_cnt   <= '0;
                r_ev    <= '0;
                r_init  <= 1'b1;
            end
            S_SQ_LO:  r_hi_sq <= w_p[63:0];
            S_SQ_END: begin
                r_lo_sq  <= w_p[63:0];
                r_last_t <= '0;
            end
            S_EWAIT: begin
                if (w_ev_done) begin
                    if (r_init) begin
                        case (r_ev)
                            2'd0:    r_last_x <= w_ev_res;
                            2'd1:    r_last_y <= w_ev_res;
                            2'd2:    r_end_x  <= w_ev_res;
                            default: r_end_y  <= w_ev_res;
                        endcase
                        r_ev   <= r_ev + 2'd1;
                        r_dchk <= 1'b1;
                    end else if (!r_ev[0]) begin
                        r_tx <= w_ev_res;
                        r_ev <= 2'd1;
                    end else begin
                        r_ty   <= w_ev_res;
                        r_dchk <= 1'b0;
                    end
                end
            end
            S_D0: r_my  <= w_my[31:0];
            S_D1: r_sx  <= w_p[63:0];
            S_D2: r_sum <= {1'b0, r_sx} + {1'b0, w_p[63:0]};
            S_D3: begin
                if (r_dchk) begin
                    if (r_pend) begin
                        r_ox     <= r_last_x;
                        r_oy     <= r_last_y;
                        r_ovalid <= 1'b1;
                        r_olast  <= w_stop;
                    end else begin
                        r_ox     <= '0;
                        r_oy     <= '0;
                        r_ovalid <= 1'b0;
                        r_olast  <= 1'b1;
                    end
                end else if (w_lo_hit && !w_iter_last) begin
                    r_t_low <= r_t;
                    r_iter  <= r_iter - IW'(1);
                end else if (w_hi_hit && !w_iter_last) begin
                    r_t_high <= r_t;
                    r_iter   <= r_iter - IW'(1);
                end else begin
                    // Trial accepted, or the trial budget is spent: keep this point.
                    r_last_x <= r_tx;
                    r_last_y <= r_ty;
                    r_last_t <= r_t;
                    r_cnt    <= r_cnt + 7'd1;
                    r_dchk   <= 1'b1;
                end
            end
            S_BST: begin
                r_t_low  <= r_last_t;
                r_t_high <= T_ONE;
                r_iter   <= IW'(MAX_ITER);
                r_init   <= 1'b0;
            end
            S_BIT: begin
                r_t  <= w_tsum_t;
                r_ev <= '0;
            end
            default: ;
        endcase
    end

endmodule

@@ sv/bcr_mul.sv @@
module bcr_mul import bcr_pkg::*; #(
    parameter int BW = 32
) (
    input  logic                i_clk,
    input  logic [31:0]         i_a,
    input  logic [BW-1:0]       i_b,
    output logic [31+BW:0]      o_p
);

    logic [31+BW:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (32+BW)'(i_a) * (32+BW)'(i_b);
    end

    assign o_p = r_p;

endmodule

@@ sv/bcr_eval.sv @@
module bcr_eval import bcr_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int NW = $clog2(MAX_POINTS + 1),
    localparam int TW = T_FRAC_BITS + 1,
    localparam int BW = (TW > 32) ? TW : 32,
    localparam int PW = 32 + BW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_x,
    input  logic [31:0]   i_wr_y,
    input  logic          i_start,
    input  logic          i_axis,
    input  logic [TW-1:0] i_t,
    input  logic [NW-1:0] i_n,
    output logic [31:0]   o_mul_a,
    output logic [BW-1:0] o_mul_b,
    input  logic [PW-1:0] i_mul_p,
    output logic          o_done,
    output logic [31:0]   o_result
);

    localparam logic [PW-1:0] HALF = PW'(1) << (T_FRAC_BITS - 1);

    logic [31:0] mem_x [MAX_POINTS];
    logic [31:0] mem_y [MAX_POINTS];
    logic [31:0] mem_s [MAX_POINTS];

    t_ev_state   r_state, n_state;
    logic [AW-1:0] r_len, r_i, w_raddr, w_i1;
    logic        r_first, r_axis, r_neg, r_done;
    logic [TW-1:0] r_t;
    logic [31:0] r_a, r_b, r_result, r_rdx, r_rdy, r_rds, w_src;
    logic [32:0] w_d, w_m, w_new;
    logic [PW-1:0] w_rnd;
    logic [31:0] w_r;

    assign w_i1  = r_i + AW'(1);
    assign w_src = r_first ? (r_axis ? r_rdy : r_rdx) : r_rds;
    assign w_d   = {r_a[31], r_a} - {w_src[31], w_src};
    assign w_m   = w_d[32] ? -w_d : w_d;
    assign w_rnd = (i_mul_p + HALF) >> T_FRAC_BITS;
    assign w_r   = w_rnd[31:0];
    assign w_new = r_neg ? ({r_a[31], r_a} + {1'b0, w_r}) : ({r_a[31], r_a} - {1'b0, w_r});

    assign o_mul_a  = w_m[31:0];
    assign o_mul_b  = BW'(r_t);
    assign o_done   = r_done;
    assign o_result = r_result;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            E_IDLE: if (i_start) n_state = E_LD0;
            E_LD0:  n_state = E_LDA;
            E_LDA:  n_state = E_MUL;
            E_MUL:  n_state = E_UPD;
            E_UPD: begin
                if (w_i1 == r_len) begin
                    n_state = (r_len == AW'(1)) ? E_IDLE : E_LD0;
                end else begin
                    n_state = E_RD;
                end
            end
            E_RD:   n_state = E_MUL;
            default: n_state = E_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            E_LDA:   w_raddr = AW'(1);
            E_RD:    w_raddr = w_i1;
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem_x[i_wr_addr] <= i_wr_x;
            mem_y[i_wr_addr] <= i_wr_y;
        end
        r_rdx <= mem_x[w_raddr];
        r_rdy <= mem_y[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == E_UPD) begin
            mem_s[r_i] <= w_new[31:0];
        end
        r_rds <= mem_s[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == E_UPD) && (w_i1 == r_len) && (r_len == AW'(1));
        end
        case (r_state)
            E_IDLE: begin
                r_len   <= AW'(i_n - NW'(1));
                r_first <= 1'b1;
                r_axis  <= i_axis;
                r_t     <= i_t;
            end
            E_LDA: begin
                r_a <= w_src;
                r_i <= '0;
            end
            E_MUL: begin
                r_b   <= w_src;
                r_neg <= w_d[32];
            end
            E_UPD: begin
                r_a <= r_b;
                if (w_i1 == r_len) begin
                    r_result <= w_new[31:0];
                    r_len    <= r_len - AW'(1);
                    r_first  <= 1'b0;
                end else begin
                    r_i <= w_i1;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import bcr_pkg::*;

    localparam int TF = T_FRAC_BITS_DEF;
    localparam longint unsigned T_ONE = 64'd1 << TF;
    localparam longint unsigned T_HALF = 64'd1 << (TF - 1);
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        t_kind     kind;
        bit [2:0]  idx;
        bit [31:0] x;
        bit [31:0] y;
    } t_curve_cmd;

    typedef struct {
        bit [31:0] px;
        bit [31:0] py;
        bit        pv;
        bit        lp;
    } t_curve_pt;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_kind = 1'b0;
    logic [2:0]  i_point_index = '0;
    logic [31:0] i_x_coord = '0;
    logic [31:0] i_y_coord = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_point_x;
    logic [31:0] o_point_y;
    logic        o_point_valid;
    logic        o_last_point;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    bezier_equal_chord_raster i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state.
    longint      ctl_x[8];
    longint      ctl_y[8];
    bit [3:0]    cnt_reg = POINT_COUNT_RST;
    bit [30:0]   goal_reg = GOAL_RST;
    bit [30:0]   tol_reg = TOL_RST;
    bit [6:0]    lim_reg = LIMIT_RST;

    t_curve_cmd  cmd_q[$];
    t_curve_pt   pt_q[$];
    int          errors = 0;
    bit          quiet = 0;
    bit          hold_trigger = 0;
    bit          in_taken = 0;
    bit          cfg_taken = 0;
    int          idle_cycles = 0;

    function automatic longint decasteljau(longint cp[8], int n, longint unsigned t);
        longint s[8];
        longint d;
        longint unsigned m, r;
        s = cp;
        for (int len = n - 1; len > 0; len--) begin
            for (int i = 0; i < len; i++) begin
                d = s[i] - s[i + 1];
                m = (d < 0) ? longint'(-d) : longint'(d);
                r = (m * t + T_HALF) >> TF;
                s[i] = (d < 0) ? s[i] + longint'(r) : s[i] - longint'(r);
            end
        end
        return s[0];
    endfunction

    // Squared chord length as a carry bit on top of a 64-bit sum.
    function automatic bit [64:0] chord_sq(longint ax, longint ay, longint bx, longint by);
        longint dx, dy;
        longint unsigned mx, my, sx, sum;
        dx = ax - bx;
        dy = ay - by;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        sx = mx * mx;
        sum = sx + my * my;
        return {sum < sx, sum};
    endfunction

    function automatic void raster_curve();
        int n, limit, emitted;
        longint unsigned hi_thr, lo_thr, t, lt, tl, th;
        longint lx, ly, ex, ey, x, y;
        bit [64:0] sq;
        t_curve_pt p;
        n = int'(cnt_reg);
        if (n < 2) n = 2;
        if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
        limit = (lim_reg > RESULT_CAP) ? RESULT_CAP : int'(lim_reg);
        hi_thr = longint'(goal_reg) + longint'(tol_reg);
        lo_thr = (goal_reg > tol_reg) ? longint'(goal_reg - tol_reg) : 0;
        lt = 0;
        lx = decasteljau(ctl_x, n, 0);
        ly = decasteljau(ctl_y, n, 0);
        ex = decasteljau(ctl_x, n, T_ONE);
        ey = decasteljau(ctl_y, n, T_ONE);
        for (emitted = 0; emitted < limit; emitted++) begin
            t = lt;
            x = lx;
            y = ly;
            sq = chord_sq(lx, ly, ex, ey);
            if (!sq[64] && sq[63:0] < hi_thr * hi_thr) break;
            tl = lt;
            th = T_ONE;
            for (int it = MAX_ITER_DEF; it > 0; it--) begin
                t = (tl + th) >> 1;
                x = decasteljau(ctl_x, n, t);
                y = decasteljau(ctl_y, n, t);
                sq = chord_sq(lx, ly, x, y);
                if (!sq[64] && sq[63:0] < lo_thr * lo_thr) tl = t;
                else if (sq[64] || sq[63:0] > hi_thr * hi_thr) th = t;
                else break;
            end
            lx = x;
            ly = y;
            lt = t;
            p.px = x[31:0];
            p.py = y[31:0];
            p.pv = 1'b1;
            p.lp = 1'b0;
            pt_q = {pt_q, p};
        end
        if (emitted == 0) begin
            p.px = '0;
            p.py = '0;
            p.pv = 1'b0;
            p.lp = 1'b1;
            pt_q = {pt_q, p};
        end else begin
            pt_q[pt_q.size() - 1].lp = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Acceptance, prediction and checking, all sampled at the rising edge.
    always @(posedge i_clk) begin
        t_curve_pt exp_pt;
        bit any_fire;
        any_fire = 0;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        cfg_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            any_fire = 1;
            if (i_kind == KIND_LOAD) begin
                ctl_x[i_point_index] = longint'(signed'(i_x_coord));
                ctl_y[i_point_index] = longint'(signed'(i_y_coord));
            end else begin
                raster_curve();
            end
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            any_fire = 1;
            case (t_cfg_idx'(i_cfg_index))
                CFG_POINT_COUNT: cnt_reg = i_cfg_data[3:0];
                CFG_GOAL:        goal_reg = i_cfg_data[30:0];
                CFG_TOLERANCE:   tol_reg = i_cfg_data[30:0];
                CFG_LIMIT:       lim_reg = i_cfg_data[6:0];
            endcase
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            any_fire = 1;
            if (pt_q.size() == 0) begin
                report_mismatch("result with no expected point");
            end else begin
                exp_pt = pt_q.pop_front();
                if (o_point_x !== exp_pt.px)
                    report_mismatch($sformatf("point_x %h, expected %h", o_point_x, exp_pt.px));
                if (o_point_y !== exp_pt.py)
                    report_mismatch($sformatf("point_y %h, expected %h", o_point_y, exp_pt.py));
                if (o_point_valid !== exp_pt.pv)
                    report_mismatch($sformatf("point_valid %b, expected %b",
                                              o_point_valid, exp_pt.pv));
                if (o_last_point !== exp_pt.lp)
                    report_mismatch($sformatf("last_point %b, expected %b",
                                              o_last_point, exp_pt.lp));
            end
        end
        if (any_fire || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                report_mismatch($sformatf("timeout with %0d points outstanding", pt_q.size()));
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Command driver.
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_curve_cmd c;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 6) - 1;
                i_in_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                i_kind <= c.kind;
                i_point_index <= c.idx;
                i_x_coord <= c.x;
                i_y_coord <= c.y;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure, with one long hold so the block backs up its input.
    // The hold starts once a result is waiting, so it really blocks the block.
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(negedge i_clk) begin
        if (hold_trigger && !hold_done && o_out_valid) begin
            hold_done = 1;
            hold_left = 1500;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input bit [31:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // Unused upper data bits get random values; the block must ignore them.
    task automatic set_regs(input bit [3:0] pc, input bit [30:0] goal, input bit [30:0] tol,
                            input bit [6:0] lim);
        write_reg(CFG_POINT_COUNT, {$urandom} << 4 | pc);
        write_reg(CFG_GOAL, {$urandom} << 31 | goal);
        write_reg(CFG_TOLERANCE, {$urandom} << 31 | tol);
        write_reg(CFG_LIMIT, {$urandom} << 7 | lim);
    endtask

    task automatic add_load(input int idx, input bit [31:0] x, input bit [31:0] y);
        t_curve_cmd c;
        c.kind = KIND_LOAD;
        c.idx = 3'(idx);
        c.x = x;
        c.y = y;
        cmd_q = {cmd_q, c};
    endtask

    task automatic add_raster();
        t_curve_cmd c;
        c.kind = KIND_RASTER;
        c.idx = 3'($urandom);
        c.x = $urandom;
        c.y = $urandom;
        cmd_q = {cmd_q, c};
    endtask

    // Waits until every transaction is in and every point is out, then lets the
    // block finish any trailing load before the registers are touched.
    task automatic drain();
        do @(posedge i_clk); while (cmd_q.size() != 0 || i_in_valid || pt_q.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick_coord(input int unsigned scale, input bit full);
        if (full) return $urandom;
        return $urandom_range(0, 2 * scale) - scale;
    endfunction

    task automatic random_phase(input int n_items);
        int unsigned scale;
        bit full;
        bit [3:0] pc;
        bit [30:0] goal, tol;
        bit [6:0] lim;
        full = 0;
        case ($urandom_range(0, 3))
            0: scale = 32'd65536 * $urandom_range(1, 8);
            1: scale = 32'd1 << 20;
            2: scale = 32'd1 << 24;
            default: begin
                scale = 32'h7fff_ffff;
                full = 1;
            end
        endcase
        pc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(2, 5));
        goal = 31'(scale / $urandom_range(1, 3));
        if (goal == 0) goal = 1;
        tol = goal >> $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0) goal = 31'($urandom);
        if ($urandom_range(0, 7) == 0) tol = 31'($urandom);
        case ($urandom_range(0, 9))
            0: lim = 0;
            1: lim = full ? 7'd8 : 7'($urandom_range(64, 127));
            default: lim = 7'($urandom_range(1, 8));
        endcase
        set_regs(pc, goal, tol, lim);
        for (int i = 0; i < 8; i++)
            add_load(i, pick_coord(scale, full), pick_coord(scale, full));
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) < 7)
                add_load($urandom_range(0, 7), pick_coord(scale, full), pick_coord(scale, full));
            else
                add_raster();
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values with a small cubic.
        for (int i = 0; i < 8; i++)
            add_load(i, $urandom_range(0, 32'h80000) - 32'h40000,
                     $urandom_range(0, 32'h80000) - 32'h40000);
        add_raster();
        drain();

        // Extreme coordinates, exact chord demanded: no trial is ever accepted.
        set_regs(4'd2, 31'h7fff_ffff, 31'd0, 7'd2);
        add_load(0, 32'h8000_0000, 32'h7fff_ffff);
        add_load(1, 32'h7fff_ffff, 32'h8000_0000);
        add_raster();
        drain();

        // Tolerance not below goal: the low threshold is zero, so no trial falls short.
        set_regs(4'd8, 31'd100, 31'h7fff_ffff, 7'd64);
        add_raster();
        drain();

        // Limit of zero gives the empty marker; count below two acts as two.
        set_regs(4'd0, 31'd1, 31'd0, 7'd0);
        add_raster();
        drain();

        // Limit above the cap, count above the store, with a long output hold.
        set_regs(4'd15, 31'h40000, 31'h20000, 7'd127);
        for (int i = 0; i < 8; i++)
            add_load(i, $urandom_range(0, 32'h400000) - 32'h200000,
                     $urandom_range(0, 32'h400000) - 32'h200000);
        hold_trigger = 1;
        add_raster();
        add_load(3, 32'h0001_0000, 32'hffff_0000);
        add_raster();
        drain();

        for (int p = 0; p < 12; p++) begin
            if (p >= 10) quiet = 1;
            random_phase(18);
        end

        repeat (100) @(posedge i_clk);
        if (pt_q.size() != 0)
            report_mismatch($sformatf("%0d expected points never seen", pt_q.size()));
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
